@@ rtl/bicubic_image_sampler_assert.svh @@
// ----------------------------------------------------------------------------
// Bicubic image sampler assertion macros
// Shared property forms for the concurrent checks of the sampler.
// ----------------------------------------------------------------------------
`ifndef BICUBIC_IMAGE_SAMPLER_ASSERT_SVH
`define BICUBIC_IMAGE_SAMPLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIS_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BIS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/bis_pkg.sv @@
// ----------------------------------------------------------------------------
// Bicubic image sampler package
// Shared constants, codes, types and width helpers.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int DEF_FRAC_BITS    = 8;

    localparam int COORD_W   = 18;
    localparam int WADDR_W   = 18;
    localparam int WVAL_W    = 16;
    localparam int DIM_W     = 9;
    localparam int CHCNT_W   = 3;
    localparam int CHAN_W    = 2;
    localparam int MARGIN_W  = 8;
    localparam int OUT_W     = 26;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;
    localparam int PROD_W    = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_MARGIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTSIDE_AS_NAN = 3'd4;

    localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH    = 9'd256;
    localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT   = 9'd256;
    localparam logic [CHCNT_W-1:0]  RST_CHANNEL_COUNT  = 3'd1;
    localparam logic [MARGIN_W-1:0] RST_BORDER_MARGIN  = 8'd0;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ISSUE,
        ST_WAIT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic valid;
        logic write;
    } op_t;

    function automatic int col_width(input int sb, input int fb);
        return sb + fb + 3;
    endfunction

    function automatic int acc_width(input int sb, input int fb);
        return col_width(sb, fb) + 3 * fb + 6;
    endfunction

endpackage

@@ rtl/bis_store.sv @@
// ----------------------------------------------------------------------------
// Bicubic image sampler store
// Single-port synchronous sample memory with a registered read port.
// ----------------------------------------------------------------------------
module bis_store
    import bis_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int DEPTH       = DEF_MAX_WIDTH * DEF_MAX_HEIGHT * DEF_MAX_CHANNELS,
    parameter int AW          = $clog2(DEPTH)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  op_t                    op,
    input  logic [AW-1:0]          addr,
    input  logic [SAMPLE_BITS-1:0] wdata,
    output logic                   rvalid,
    output logic [SAMPLE_BITS-1:0] rdata
);

    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic                   rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (op.valid)
        begin
            if (op.write)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= op.valid && !op.write;
        end
    end

    assign rvalid = rvalid_reg;

endmodule

@@ rtl/bis_addr_pipe.sv @@
// ----------------------------------------------------------------------------
// Bicubic image sampler address pipeline
// Forms store addresses for sample writes and neighbour reads, in order.
// ----------------------------------------------------------------------------
module bis_addr_pipe
    import bis_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int DEPTH       = DEF_MAX_WIDTH * DEF_MAX_HEIGHT * DEF_MAX_CHANNELS,
    parameter int AW          = $clog2(DEPTH)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  op_t                    op_in,
    input  logic [WADDR_W-1:0]     waddr,
    input  logic [SAMPLE_BITS-1:0] wdata_in,
    input  logic [DIM_W-1:0]       ix,
    input  logic [DIM_W-1:0]       iy,
    input  logic [DIM_W-1:0]       image_width,
    input  logic [CHCNT_W-1:0]     channel_count,
    input  logic [CHAN_W-1:0]      chan,
    output op_t                    op_out,
    output logic [AW-1:0]          addr,
    output logic [SAMPLE_BITS-1:0] wdata_out
);

    localparam int RW = PROD_W + 2;
    localparam int SH = PROD_W + AW;
    localparam int MW = ((PROD_W > AW) ? PROD_W : AW) + 2;
    localparam longint RECIP = (longint'(1) <<< SH) / longint'(DEPTH);

    op_t                    s1_op_reg, s2_op_reg, s3_op_reg, s4_op_reg;
    logic [PROD_W-1:0]      s1_p_reg, s2_p_reg, s3_p_reg;
    logic [PROD_W-1:0]      s3_q_reg;
    logic [AW-1:0]          s4_addr_reg;
    logic [SAMPLE_BITS-1:0] s1_d_reg, s2_d_reg, s3_d_reg, s4_d_reg;
    logic [PROD_W-1:0]      s1_p_next, s2_p_next, s3_q_next;
    logic [PROD_W+RW-1:0]   prod;
    logic [MW-1:0]          rem, rem_fix;

    always_comb
    begin
        if (op_in.write)
        begin
            s1_p_next = PROD_W'(waddr);
        end
        else
        begin
            s1_p_next = PROD_W'(image_width) * PROD_W'(iy) + PROD_W'(ix);
        end
        if (s1_op_reg.write)
        begin
            s2_p_next = s1_p_reg;
        end
        else
        begin
            s2_p_next = s1_p_reg * PROD_W'(channel_count) + PROD_W'(chan);
        end
        prod      = (PROD_W+RW)'(s2_p_reg) * (PROD_W+RW)'(RECIP);
        s3_q_next = PROD_W'(prod >> SH);
        rem       = MW'(s3_p_reg) - MW'(s3_q_reg) * MW'(DEPTH);
        rem_fix   = (rem >= MW'(DEPTH)) ? (rem - MW'(DEPTH)) : rem;
    end

    always_ff @(posedge clk)
    begin
        s1_p_reg    <= s1_p_next;
        s1_d_reg    <= wdata_in;
        s2_p_reg    <= s2_p_next;
        s2_d_reg    <= s1_d_reg;
        s3_p_reg    <= s2_p_reg;
        s3_q_reg    <= s3_q_next;
        s3_d_reg    <= s2_d_reg;
        s4_addr_reg <= AW'(rem_fix);
        s4_d_reg    <= s3_d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_op_reg <= '0;
            s2_op_reg <= '0;
            s3_op_reg <= '0;
            s4_op_reg <= '0;
        end
        else
        begin
            s1_op_reg <= op_in;
            s2_op_reg <= s1_op_reg;
            s3_op_reg <= s2_op_reg;
            s4_op_reg <= s3_op_reg;
        end
    end

    assign op_out    = s4_op_reg;
    assign addr      = s4_addr_reg;
    assign wdata_out = s4_d_reg;

endmodule

@@ rtl/bis_cubic.sv @@
// ----------------------------------------------------------------------------
// Bicubic image sampler cubic unit
// Pipelined Keys cubic kernel evaluated in Horner form with rounding.
// ----------------------------------------------------------------------------
module bis_cubic
    import bis_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int CB          = col_width(SAMPLE_BITS, FRAC_BITS),
    parameter int ACC_W       = acc_width(SAMPLE_BITS, FRAC_BITS)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    xpass_in,
    input  logic signed [CB-1:0]    v [4],
    input  logic [FRAC_BITS-1:0]    frac,
    output logic                    res_valid,
    output logic                    xpass_out,
    output logic signed [ACC_W-1:0] res
);

    localparam logic signed [ACC_W-1:0] HALF_Y = ACC_W'(1) <<< (2 * FRAC_BITS);
    localparam logic signed [ACC_W-1:0] HALF_X = ACC_W'(1) <<< (3 * FRAC_BITS);

    logic signed [CB-1:0]    s0_v_reg [4];
    logic [FRAC_BITS-1:0]    s0_f_reg, s1_f_reg, s2_f_reg;
    logic [2:0]              vld_reg;
    logic [3:0]              x_reg;
    logic                    s3_vld_reg;
    logic signed [ACC_W-1:0] e0, e1, e2, e3, ka, kb, h1_next, h2_next, h3_next;
    logic signed [ACC_W-1:0] s1_h_reg, s1_d_reg, s1_m_reg;
    logic signed [ACC_W-1:0] s2_h_reg, s2_m_reg, s3_h_reg;
    logic signed [FRAC_BITS:0] f0, f1, f2;

    always_comb
    begin
        e0 = ACC_W'(s0_v_reg[0]);
        e1 = ACC_W'(s0_v_reg[1]);
        e2 = ACC_W'(s0_v_reg[2]);
        e3 = ACC_W'(s0_v_reg[3]);
        f0 = $signed({1'b0, s0_f_reg});
        f1 = $signed({1'b0, s1_f_reg});
        f2 = $signed({1'b0, s2_f_reg});
        ka = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
        kb = ((e1 - e2) <<< 1) + (e1 - e2) + e3 - e0;
        h1_next = (ka <<< FRAC_BITS) + f0 * kb;
        h2_next = (s1_d_reg <<< (2 * FRAC_BITS)) + f1 * s1_h_reg;
        h3_next = (s2_m_reg <<< (3 * FRAC_BITS + 1)) + f2 * s2_h_reg;
        if (x_reg[3])
        begin
            res = (s3_h_reg + HALF_X) >>> (3 * FRAC_BITS + 1);
        end
        else
        begin
            res = (s3_h_reg + HALF_Y) >>> (2 * FRAC_BITS + 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s0_v_reg <= v;
            s0_f_reg <= frac;
        end
        s1_h_reg <= h1_next;
        s1_d_reg <= e2 - e0;
        s1_m_reg <= e1;
        s1_f_reg <= s0_f_reg;
        s2_h_reg <= h2_next;
        s2_m_reg <= s1_m_reg;
        s2_f_reg <= s1_f_reg;
        s3_h_reg <= h3_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            x_reg      <= '0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg    <= {vld_reg[1:0], start};
            x_reg      <= {x_reg[2:0], xpass_in && start};
            s3_vld_reg <= vld_reg[2];
        end
    end

    assign res_valid = s3_vld_reg;
    assign xpass_out = x_reg[3];

endmodule

@@ rtl/bicubic_image_sampler.sv @@
// ----------------------------------------------------------------------------
// Bicubic image sampler
// Catmull-Rom interpolation over an interleaved multichannel image store.
//
// Channel   Signals                                  Direction
// req       req_valid/req_stall, req_type..channel   in, stall driven here
// rsp       rsp_valid/rsp_stall, interp_value,is_nan out, stall driven by sink
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data in, always ready
//
// A sample write is taken every cycle while no query is in progress and
// produces no transaction on rsp. A query inside the margin makes sixteen
// reads through the single-port store, the four-stage address pipeline and
// four vertical and one horizontal cubic pass; an outside query skips these.
// A stalled rsp blocks new requests only once the next query result is waiting.
// The store has no reset; all control and configuration registers reset.
// ----------------------------------------------------------------------------
module bicubic_image_sampler
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic                     req_type,
    input  logic [WADDR_W-1:0]       sample_address,
    input  logic [WVAL_W-1:0]        sample_value,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic [CHAN_W-1:0]        channel,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic signed [OUT_W-1:0]  interp_value,
    output logic                     is_nan,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DAT_W-1:0]     cfg_data
);

    `include "bicubic_image_sampler_assert.svh"

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CB    = col_width(SAMPLE_BITS, FRAC_BITS);
    localparam int ACC_W = acc_width(SAMPLE_BITS, FRAC_BITS);
    localparam int CMP_W = 20 + FRAC_BITS;
    localparam int IW    = 20;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'sd1 <<< (OUT_W - 1));

    state_t state_reg, state_next;

    logic [DIM_W-1:0]    width_reg, height_reg;
    logic [CHCNT_W-1:0]  chcnt_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic                nan_cfg_reg;

    logic signed [COORD_W-1:0] qx_reg, qy_reg;
    logic [CHAN_W-1:0]         qk_reg;
    logic [DIM_W-1:0]          ix_reg [4];
    logic [DIM_W-1:0]          iy_reg [4];
    logic [FRAC_BITS-1:0]      fx_reg, fy_reg;
    logic [3:0]                cnt_reg;
    logic [1:0]                rd_cnt_reg, col_cnt_reg;
    logic [SAMPLE_BITS-1:0]    samp_reg [3];
    logic signed [CB-1:0]      col_reg [3];
    logic signed [OUT_W-1:0]   res_val_reg;
    logic                      res_nan_reg;
    logic                      rsp_valid_reg;
    logic signed [OUT_W-1:0]   rsp_val_reg;
    logic                      rsp_nan_reg;

    logic accept, issue, rsp_free, load_rsp, outside;
    logic signed [CMP_W-1:0] xs, ys, lo, hix, hiy;
    logic signed [IW-1:0]    xi, yi;
    logic [DIM_W-1:0]        ix_next [4];
    logic [DIM_W-1:0]        iy_next [4];

    op_t                    pipe_in, pipe_out;
    logic [AW-1:0]          mem_addr;
    logic [SAMPLE_BITS-1:0] mem_wdata, rdata;
    logic                   rvalid;
    logic                   cub_start, cub_xin, cub_valid, cub_xout;
    logic signed [CB-1:0]   cub_v [4];
    logic [FRAC_BITS-1:0]   cub_f;
    logic signed [ACC_W-1:0] cub_res, sat;
    logic                   y_done, x_done;

    function automatic logic [DIM_W-1:0] clamp_idx(input logic signed [IW-1:0] t,
                                                   input logic [DIM_W-1:0] n);
        logic [DIM_W-1:0] r;
        if (t < 0)
        begin
            r = '0;
        end
        else if (t >= $signed(IW'(n)))
        begin
            r = n - 1'b1;
        end
        else
        begin
            r = DIM_W'(t);
        end
        return r;
    endfunction

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_type == REQ_QUERY)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = outside ? ST_RESULT : ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (cnt_reg == 4'hF)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (x_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        rsp_free  = !rsp_valid_reg || !rsp_stall;
        req_stall = (state_reg != ST_IDLE);
        issue     = (state_reg == ST_ISSUE);
        load_rsp  = (state_reg == ST_RESULT) && rsp_free;
    end

    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        xs  = CMP_W'(qx_reg);
        ys  = CMP_W'(qy_reg);
        lo  = $signed(CMP_W'(margin_reg)) <<< FRAC_BITS;
        hix = ($signed(CMP_W'(width_reg)) - CMP_W'(1) - $signed(CMP_W'(margin_reg)))
              <<< FRAC_BITS;
        hiy = ($signed(CMP_W'(height_reg)) - CMP_W'(1) - $signed(CMP_W'(margin_reg)))
              <<< FRAC_BITS;
        outside = (xs < lo) || (xs > hix) || (ys < lo) || (ys > hiy);
        xi = IW'(qx_reg) >>> FRAC_BITS;
        yi = IW'(qy_reg) >>> FRAC_BITS;
        for (int n = 0; n < 4; n++)
        begin
            ix_next[n] = clamp_idx(xi - IW'(1) + IW'(n), width_reg);
            iy_next[n] = clamp_idx(yi - IW'(1) + IW'(n), height_reg);
        end
    end

    always_comb
    begin
        pipe_in.valid = (accept && req_type == REQ_WRITE) || issue;
        pipe_in.write = !issue;
    end

    bis_addr_pipe #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DEPTH       (DEPTH),
        .AW          (AW)
    ) u_addr_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .op_in         (pipe_in),
        .waddr         (sample_address),
        .wdata_in      (SAMPLE_BITS'(sample_value)),
        .ix            (ix_reg[cnt_reg[3:2]]),
        .iy            (iy_reg[cnt_reg[1:0]]),
        .image_width   (width_reg),
        .channel_count (chcnt_reg),
        .chan          (qk_reg),
        .op_out        (pipe_out),
        .addr          (mem_addr),
        .wdata_out     (mem_wdata)
    );

    bis_store #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DEPTH       (DEPTH),
        .AW          (AW)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (pipe_out),
        .addr   (mem_addr),
        .wdata  (mem_wdata),
        .rvalid (rvalid),
        .rdata  (rdata)
    );

    assign y_done = cub_valid && !cub_xout;
    assign x_done = cub_valid && cub_xout;

    always_comb
    begin
        cub_xin   = y_done && (col_cnt_reg == 2'd3);
        cub_start = (rvalid && (rd_cnt_reg == 2'd3)) || cub_xin;
        if (cub_xin)
        begin
            cub_v[0] = col_reg[0];
            cub_v[1] = col_reg[1];
            cub_v[2] = col_reg[2];
            cub_v[3] = CB'(cub_res);
            cub_f    = fx_reg;
        end
        else
        begin
            cub_v[0] = $signed(CB'(samp_reg[0]));
            cub_v[1] = $signed(CB'(samp_reg[1]));
            cub_v[2] = $signed(CB'(samp_reg[2]));
            cub_v[3] = $signed(CB'(rdata));
            cub_f    = fy_reg;
        end
        if (cub_res > SAT_HI)
        begin
            sat = SAT_HI;
        end
        else if (cub_res < SAT_LO)
        begin
            sat = SAT_LO;
        end
        else
        begin
            sat = cub_res;
        end
    end

    bis_cubic #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .CB          (CB),
        .ACC_W       (ACC_W)
    ) u_cubic (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cub_start),
        .xpass_in  (cub_xin),
        .v         (cub_v),
        .frac      (cub_f),
        .res_valid (cub_valid),
        .xpass_out (cub_xout),
        .res       (cub_res)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qx_reg <= coord_x;
            qy_reg <= coord_y;
            qk_reg <= channel;
        end
        if (state_reg == ST_CHECK)
        begin
            ix_reg      <= ix_next;
            iy_reg      <= iy_next;
            fx_reg      <= FRAC_BITS'(qx_reg);
            fy_reg      <= FRAC_BITS'(qy_reg);
            res_val_reg <= '0;
            res_nan_reg <= outside && nan_cfg_reg;
        end
        if (rvalid)
        begin
            samp_reg[0] <= samp_reg[1];
            samp_reg[1] <= samp_reg[2];
            samp_reg[2] <= rdata;
        end
        if (y_done)
        begin
            col_reg[0] <= col_reg[1];
            col_reg[1] <= col_reg[2];
            col_reg[2] <= CB'(cub_res);
        end
        if (x_done)
        begin
            res_val_reg <= OUT_W'(sat);
            res_nan_reg <= 1'b0;
        end
        if (load_rsp)
        begin
            rsp_val_reg <= res_val_reg;
            rsp_nan_reg <= res_nan_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_cnt_reg    <= '0;
            col_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            width_reg     <= RST_IMAGE_WIDTH;
            height_reg    <= RST_IMAGE_HEIGHT;
            chcnt_reg     <= RST_CHANNEL_COUNT;
            margin_reg    <= RST_BORDER_MARGIN;
            nan_cfg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CHECK)
            begin
                cnt_reg     <= '0;
                rd_cnt_reg  <= '0;
                col_cnt_reg <= '0;
            end
            else
            begin
                if (issue)
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                end
                if (rvalid)
                begin
                    rd_cnt_reg <= rd_cnt_reg + 2'd1;
                end
                if (y_done)
                begin
                    col_cnt_reg <= col_cnt_reg + 2'd1;
                end
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_IMAGE_WIDTH:    width_reg   <= cfg_data;
                    CFG_IMAGE_HEIGHT:   height_reg  <= cfg_data;
                    CFG_CHANNEL_COUNT:  chcnt_reg   <= cfg_data[CHCNT_W-1:0];
                    CFG_BORDER_MARGIN:  margin_reg  <= cfg_data[MARGIN_W-1:0];
                    CFG_OUTSIDE_AS_NAN: nan_cfg_reg <= cfg_data[0];
                    default:            ;
                endcase
            end
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign interp_value = rsp_val_reg;
    assign is_nan       = rsp_nan_reg;

    `BIS_ASSERT_SAME(a_xpass_in_wait, x_done, state_reg == ST_WAIT,
        "Horizontal pass result outside the wait state")
    `BIS_ASSERT_SAME(a_read_in_query, rvalid,
        state_reg == ST_ISSUE || state_reg == ST_WAIT,
        "Store read data returned with no query in progress")
    `BIS_ASSERT_NEXT(a_check_after_query, accept && req_type == REQ_QUERY,
        state_reg == ST_CHECK, "Accepted query did not enter the check state")

endmodule
